FILE: hdl/pcom_pkg.sv
// shared types and constants for the periodic center of mass block
package pcom_pkg;

  localparam int POS_W  = 24;
  localparam int EXT_W  = 23;
  localparam int MASS_W = 16;
  localparam int SUM_W  = 56;
  localparam int MTOT_W = 32;
  localparam int AXES   = 3;

  // one quotient bit per divide step
  localparam int DIV_STEPS = SUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_LOAD,
    ST_DIVIDE,
    ST_SIGN,
    ST_WRAP,
    ST_OUTPUT
  } pcom_state_t;

  typedef struct packed {
    logic take;       // input transfer this cycle
    logic load;       // capture sums into the divider, clear group
    logic div_step;   // one restoring divide step
    logic sign;       // apply quotient sign
    logic wrap;       // wrap centroid against box center
    logic out_load;   // load the result register
  } pcom_cmd_t;

  typedef struct packed {
    logic group_end;  // last atom accumulates this cycle
    logic skip_div;   // single atom or zero mass group
    logic out_free;   // result register can take a new result
  } pcom_status_t;

endpackage

FILE: hdl/periodic_center_of_mass.sv
// top level of the periodic center of mass block
// throughput: one atom per cycle inside a group; after the last atom transfer the input
// stalls through drain, load, 56 divide steps, sign, wrap and output, through drain, load
// and output only for a single atom or zero mass, and longer while the previous result is
// still held on the output
// reset: rst is synchronous, clears box extents, group state, controller and out_valid
module periodic_center_of_mass (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_en,
  input  logic [pcom_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcom_pkg::EXT_W-1:0]         cfg_data,
  // atom input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [pcom_pkg::POS_W-1:0]  pos_x,
  input  logic signed [pcom_pkg::POS_W-1:0]  pos_y,
  input  logic signed [pcom_pkg::POS_W-1:0]  pos_z,
  input  logic [pcom_pkg::MASS_W-1:0]        atom_mass,
  input  logic                               last_atom,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pcom_pkg::POS_W-1:0]  com_x,
  output logic signed [pcom_pkg::POS_W-1:0]  com_y,
  output logic signed [pcom_pkg::POS_W-1:0]  com_z,
  output logic                               zero_mass_error
);
  import pcom_pkg::*;

  // commands from the controller, status back from the datapath
  pcom_cmd_t    cmd;
  pcom_status_t status;

  // controller: takes atoms until the last one of a group, waits for the
  // accumulate pipeline to drain, steps the divider and hands the result to
  // the output register; a waiting result does not block the next group
  pcom_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_atom (last_atom),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // datapath: minimum image against the first atom at transfer, multiply,
  // saturating accumulate, then divide, sign, wrap and saturate per axis
  pcom_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_en          (cfg_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .atom_mass       (atom_mass),
    .last_atom       (last_atom),
    .cmd             (cmd),
    .status          (status),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .com_x           (com_x),
    .com_y           (com_y),
    .com_z           (com_z),
    .zero_mass_error (zero_mass_error)
  );

endmodule

FILE: hdl/pcom_ctrl.sv
// controller state machine for the periodic center of mass block
module pcom_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  last_atom,
  input  pcom_pkg::pcom_status_t status,
  output logic                  in_stall,
  output pcom_pkg::pcom_cmd_t   cmd
);
  import pcom_pkg::*;

  pcom_state_t      state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             take;

  assign take = in_valid && (state == ST_ACCUM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM:  if (take && last_atom) state_next = ST_DRAIN;
      ST_DRAIN:  if (status.group_end) state_next = ST_LOAD;
      ST_LOAD:   state_next = status.skip_div ? ST_OUTPUT : ST_DIVIDE;
      ST_DIVIDE: if (count == CNT_W'(DIV_STEPS - 1)) state_next = ST_SIGN;
      ST_SIGN:   state_next = ST_WRAP;
      ST_WRAP:   state_next = ST_OUTPUT;
      ST_OUTPUT: if (status.out_free) state_next = ST_ACCUM;
      default:   state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    count_next   = '0;
    in_stall     = (state != ST_ACCUM);
    cmd          = '0;
    cmd.take     = take;
    case (state)
      ST_LOAD:   cmd.load = 1'b1;
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        count_next   = count + 1'b1;
      end
      ST_SIGN:   cmd.sign = 1'b1;
      ST_WRAP:   cmd.wrap = 1'b1;
      ST_OUTPUT: cmd.out_load = status.out_free;
      default:   cmd.load = 1'b0;
    endcase
  end

endmodule

FILE: hdl/pcom_datapath.sv
// datapath: box registers, minimum image, accumulation, divider and result register
module pcom_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_en,
  input  logic [pcom_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcom_pkg::EXT_W-1:0]           cfg_data,
  input  logic signed [pcom_pkg::POS_W-1:0]    pos_x,
  input  logic signed [pcom_pkg::POS_W-1:0]    pos_y,
  input  logic signed [pcom_pkg::POS_W-1:0]    pos_z,
  input  logic [pcom_pkg::MASS_W-1:0]          atom_mass,
  input  logic                                 last_atom,
  input  pcom_pkg::pcom_cmd_t                  cmd,
  output pcom_pkg::pcom_status_t               status,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [pcom_pkg::POS_W-1:0]    com_x,
  output logic signed [pcom_pkg::POS_W-1:0]    com_y,
  output logic signed [pcom_pkg::POS_W-1:0]    com_z,
  output logic                                 zero_mass_error
);
  import pcom_pkg::*;

  localparam logic signed [57:0] OUT_HI = 58'sd8388607;
  localparam logic signed [57:0] OUT_LO = -58'sd8388608;

  // image of p nearest to r, one extent at most
  function automatic logic signed [POS_W:0] near_image(
    input logic signed [POS_W-1:0] p,
    input logic signed [POS_W-1:0] r,
    input logic [EXT_W-1:0]        e,
    input logic                    en
  );
    logic signed [POS_W:0] d;
    logic [POS_W:0]        abs_d;
    logic [POS_W+1:0]      mag;
    logic signed [POS_W:0] pe;
    d     = {p[POS_W-1], p} - {r[POS_W-1], r};
    abs_d = d[POS_W] ? -d : d;
    mag   = {abs_d, 1'b0};
    pe    = {p[POS_W-1], p};
    if (en && (d != '0) && (mag >= {3'b0, e})) begin
      pe = d[POS_W] ? pe + {2'b0, e} : pe - {2'b0, e};
    end
    return pe;
  endfunction

  logic [EXT_W-1:0]        ext [AXES];
  logic signed [POS_W-1:0] pos [AXES];
  logic signed [POS_W-1:0] ref_pos [AXES];
  logic                    have_ref;
  logic                    single;

  logic                    v1, v2;
  logic signed [POS_W:0]   p1 [AXES];
  logic [MASS_W-1:0]       m1, m2;
  logic                    last1, last2;
  logic signed [41:0]      prod [AXES];

  logic signed [SUM_W-1:0] sum [AXES];
  logic [MTOT_W-1:0]       mass_total;
  logic signed [SUM_W:0]   sum_wide [AXES];
  logic [MTOT_W:0]         mass_wide;

  logic [SUM_W-1:0]        dvd [AXES];
  logic [MTOT_W-1:0]       rem [AXES];
  logic [MTOT_W:0]         rem_sh [AXES];
  logic                    neg [AXES];
  logic [MTOT_W-1:0]       divisor;
  logic                    single_q, zero_q;

  logic signed [SUM_W:0]   cval [AXES];
  logic signed [58:0]      d2 [AXES];
  logic [58:0]             d2_mag [AXES];
  logic signed [57:0]      wv_next [AXES];
  logic signed [57:0]      wv [AXES];
  logic signed [POS_W-1:0] res [AXES];

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  // box extents
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) ext[i] <= '0;
    end else if (cfg_en) begin
      if (cfg_index == CFG_BOX_X) ext[0] <= cfg_data;
      if (cfg_index == CFG_BOX_Y) ext[1] <= cfg_data;
      if (cfg_index == CFG_BOX_Z) ext[2] <= cfg_data;
    end
  end

  // stage 1: reference capture and minimum image
  always_ff @(posedge clk) begin
    if (rst) begin
      have_ref <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      v1 <= cmd.take;
      v2 <= v1;
      if (cmd.take) have_ref <= !last_atom;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      for (int i = 0; i < AXES; i++) begin
        p1[i] <= near_image(pos[i], ref_pos[i], ext[i], have_ref);
        if (!have_ref) ref_pos[i] <= pos[i];
      end
      m1    <= atom_mass;
      last1 <= last_atom;
      if (last_atom) single <= !have_ref;
    end
  end

  // stage 2: mass times position
  always_ff @(posedge clk) begin
    if (v1) begin
      for (int i = 0; i < AXES; i++) prod[i] <= p1[i] * $signed({1'b0, m1});
      m2    <= m1;
      last2 <= last1;
    end
  end

  // stage 3: saturating accumulation
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sum_wide[i] = {sum[i][SUM_W-1], sum[i]} + {{(SUM_W-41){prod[i][41]}}, prod[i]};
    end
    mass_wide = {1'b0, mass_total} + {{(MTOT_W-MASS_W+1){1'b0}}, m2};
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      for (int i = 0; i < AXES; i++) sum[i] <= '0;
      mass_total <= '0;
    end else if (v2) begin
      for (int i = 0; i < AXES; i++) begin
        if (sum_wide[i][SUM_W] != sum_wide[i][SUM_W-1]) begin
          sum[i] <= sum_wide[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          sum[i] <= sum_wide[i][SUM_W-1:0];
        end
      end
      mass_total <= mass_wide[MTOT_W] ? '1 : mass_wide[MTOT_W-1:0];
    end
  end

  assign status.group_end = v2 && last2;
  assign status.skip_div  = single || (mass_total == '0);
  assign status.out_free  = !out_valid || !out_stall;

  // restoring divide on magnitudes, one quotient bit per step
  always_comb begin
    for (int i = 0; i < AXES; i++) rem_sh[i] = {rem[i], dvd[i][SUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < AXES; i++) begin
        neg[i] <= sum[i][SUM_W-1];
        dvd[i] <= sum[i][SUM_W-1] ? -sum[i] : sum[i];
        rem[i] <= '0;
      end
      divisor  <= mass_total;
      single_q <= single;
      zero_q   <= (mass_total == '0);
    end else if (cmd.div_step) begin
      for (int i = 0; i < AXES; i++) begin
        if (rem_sh[i] >= {1'b0, divisor}) begin
          rem[i] <= MTOT_W'(rem_sh[i] - {1'b0, divisor});
          dvd[i] <= {dvd[i][SUM_W-2:0], 1'b1};
        end else begin
          rem[i] <= rem_sh[i][MTOT_W-1:0];
          dvd[i] <= {dvd[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // signed quotient, then one wrap against the box center
  always_ff @(posedge clk) begin
    if (cmd.sign) begin
      for (int i = 0; i < AXES; i++) begin
        cval[i] <= neg[i] ? -$signed({1'b0, dvd[i]}) : $signed({1'b0, dvd[i]});
      end
    end
    if (cmd.wrap) begin
      for (int i = 0; i < AXES; i++) wv[i] <= wv_next[i];
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      d2[i]     = $signed({cval[i][SUM_W], cval[i], 1'b0}) - $signed({36'b0, ext[i]});
      d2_mag[i] = d2[i][58] ? -d2[i] : d2[i];
      wv_next[i] = {cval[i][SUM_W], cval[i]};
      if ((d2[i] != '0) && (d2_mag[i] >= {36'b0, ext[i]})) begin
        wv_next[i] = d2[i][58] ? wv_next[i] + $signed({35'b0, ext[i]})
                               : wv_next[i] - $signed({35'b0, ext[i]});
      end
    end
  end

  // result select and saturation
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (single_q)              res[i] = ref_pos[i];
      else if (zero_q)           res[i] = '0;
      else if (wv[i] > OUT_HI)   res[i] = OUT_HI[POS_W-1:0];
      else if (wv[i] < OUT_LO)   res[i] = OUT_LO[POS_W-1:0];
      else                       res[i] = wv[i][POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      com_x           <= res[0];
      com_y           <= res[1];
      com_z           <= res[2];
      zero_mass_error <= zero_q && !single_q;
    end
  end

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the periodic center of mass block
`timescale 1ns / 1ps

module tb_top;
  import pcom_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 80;     // margin over the divider tail
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 115;
  localparam int PRESS_PHASE  = 3;
  localparam logic [EXT_W-1:0] EXT_MAX = '1;

  // one center of mass result as seen on the output side
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    err;
  } com_t;

  // minimum image centroid predictor and result store
  class centroid_board;
    localparam longint SUM_HI   = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO   = -SUM_HI - 1;
    localparam longint MTOT_MAX = (longint'(1) <<< MTOT_W) - 1;
    localparam longint OUT_HI   = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint OUT_LO   = -OUT_HI - 1;

    longint extent [AXES];
    longint anchor [AXES];
    longint wsum [AXES];
    longint mass_sum;
    bit     anchored;
    com_t   com_q [$];
    int     mismatches;

    function new();
      for (int a = 0; a < AXES; a++) extent[a] = 0;
      mismatches = 0;
      clear_group();
    endfunction

    function void clear_group();
      for (int a = 0; a < AXES; a++) begin
        anchor[a] = 0;
        wsum[a] = 0;
      end
      mass_sum = 0;
      anchored = 1'b0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // shift p by one extent toward the center when |d2| reaches the extent
    function longint fold(longint p, longint d2, longint e);
      longint mag;
      mag = (d2 < 0) ? -d2 : d2;
      if (d2 == 0 || mag < e) return p;
      return (d2 > 0) ? p - e : p + e;
    endfunction

    function int pending();
      return com_q.size();
    endfunction

    function void take_atom(longint px, longint py, longint pz, longint m, bit last);
      longint p [AXES];
      longint q [AXES];
      com_t   r;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      if (!anchored) begin
        if (last) begin
          r.x = px[POS_W-1:0];
          r.y = py[POS_W-1:0];
          r.z = pz[POS_W-1:0];
          r.err = 1'b0;
          com_q = {com_q, r};
          clear_group();
          return;
        end
        anchor = p;
        anchored = 1'b1;
      end else begin
        for (int a = 0; a < AXES; a++)
          p[a] = fold(p[a], 2 * (p[a] - anchor[a]), extent[a]);
      end
      for (int a = 0; a < AXES; a++)
        wsum[a] = clamp(wsum[a] + p[a] * m, SUM_LO, SUM_HI);
      mass_sum = mass_sum + m;
      if (mass_sum > MTOT_MAX) mass_sum = MTOT_MAX;
      if (!last) return;
      for (int a = 0; a < AXES; a++) begin
        if (mass_sum == 0) begin
          q[a] = 0;
        end else begin
          q[a] = wsum[a] / mass_sum;
          q[a] = clamp(fold(q[a], 2 * q[a] - extent[a], extent[a]), OUT_LO, OUT_HI);
        end
      end
      r.x = q[0][POS_W-1:0];
      r.y = q[1][POS_W-1:0];
      r.z = q[2][POS_W-1:0];
      r.err = (mass_sum == 0);
      com_q = {com_q, r};
      clear_group();
    endfunction

    function void check_com(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                            logic signed [POS_W-1:0] z, logic err);
      com_t e;
      if (com_q.size() == 0) begin
        $display("%0t: result with nothing expected: %0d %0d %0d err %0b",
                 $time, x, y, z, err);
        mismatches++;
        return;
      end
      e = com_q.pop_front();
      if (e.x !== x) begin
        $display("%0t: com_x expected %0d got %0d", $time, e.x, x);
        mismatches++;
      end
      if (e.y !== y) begin
        $display("%0t: com_y expected %0d got %0d", $time, e.y, y);
        mismatches++;
      end
      if (e.z !== z) begin
        $display("%0t: com_z expected %0d got %0d", $time, e.z, z);
        mismatches++;
      end
      if (e.err !== err) begin
        $display("%0t: zero_mass_error expected %0b got %0b", $time, e.err, err);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [EXT_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [MASS_W-1:0]        atom_mass;
  logic                     last_atom;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [POS_W-1:0]  com_x;
  logic signed [POS_W-1:0]  com_y;
  logic signed [POS_W-1:0]  com_z;
  logic                     zero_mass_error;

  centroid_board sb;
  bit            tx_idle;       // sender inserts random gaps
  bit            rx_idle;       // receiver inserts random stalls
  bit            hold_request;  // ask the receiver for one long hold-off
  int            cycle_count;

  periodic_center_of_mass u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_en          (cfg_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .atom_mass       (atom_mass),
    .last_atom       (last_atom),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .com_x           (com_x),
    .com_y           (com_y),
    .com_z           (com_z),
    .zero_mass_error (zero_mass_error)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on total run length
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // one register write, lands at the next rising edge
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [EXT_W-1:0] v);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // box extents are only changed while the block is idle
  task automatic set_boxes(input logic [EXT_W-1:0] ex, input logic [EXT_W-1:0] ey,
                           input logic [EXT_W-1:0] ez);
    cfg_write(CFG_BOX_X, ex);
    cfg_write(CFG_BOX_Y, ey);
    cfg_write(CFG_BOX_Z, ez);
    cfg_en <= 1'b0;
    sb.extent[0] = ex;
    sb.extent[1] = ey;
    sb.extent[2] = ez;
  endtask

  // offer one atom, hold it until the transfer, then predict
  task automatic send_atom(input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
                           input logic signed [POS_W-1:0] pz, input logic [MASS_W-1:0] m,
                           input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    atom_mass <= m;
    last_atom <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_atom(px, py, pz, m, last);
  endtask

  // sender pause: all results in, then let the divider finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [EXT_W-1:0] pick_extent();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return EXT_MAX;
      2: return EXT_W'($urandom_range(1, 4096));
      default: return EXT_W'($urandom_range(0, 32'(EXT_MAX)));
    endcase
  endfunction

  function automatic logic [MASS_W-1:0] pick_mass();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return MASS_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // offset from the reference around half an extent, boundary hit now and then
  function automatic logic signed [POS_W-1:0] near_offset(input longint e);
    longint half;
    longint d;
    half = (e + 1) / 2;
    case ($urandom_range(0, 5))
      0: d = half;
      1: d = -half;
      2: d = half - 1;
      3: d = 1 - half;
      default: d = longint'($urandom_range(0, 32'(2 * e))) - e;
    endcase
    return d[POS_W-1:0];
  endfunction

  // one group: the first atom is the reference, most later atoms sit near it
  task automatic send_group(input int len, input bit weightless);
    logic signed [POS_W-1:0] anchor_pos [AXES];
    logic signed [POS_W-1:0] p [AXES];
    logic [MASS_W-1:0]       m;
    for (int k = 0; k < len; k++) begin
      for (int a = 0; a < AXES; a++) begin
        if (k == 0 || $urandom_range(0, 9) >= 7)
          p[a] = POS_W'($urandom());
        else
          p[a] = anchor_pos[a] + near_offset(sb.extent[a]);
      end
      if (k == 0) anchor_pos = p;
      m = weightless ? '0 : pick_mass();
      send_atom(p[0], p[1], p[2], m, k == len - 1);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int wait_cycles;
    out_stall = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        wait_cycles = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        wait_cycles = rx_idle ? $urandom_range(0, 8) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_com(com_x, com_y, com_z, zero_mass_error);
    end
  end

  // stimulus
  initial begin : stimulus
    int sent;
    int len;
    sb = new();
    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = CFG_BOX_X;
    cfg_data = '0;
    in_valid = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    atom_mass = '0;
    last_atom = 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_request = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset extents are zero: single atoms, zero mass and a weighted pair, no moves at all
    send_atom(24'sh7FFFFF, 24'sh800000, 24'sd0, 16'd0, 1'b1);
    send_atom(24'sh800000, 24'sh7FFFFF, -24'sd1, 16'hFFFF, 1'b1);
    send_atom(24'sd100, 24'sd200, 24'sd300, 16'd0, 1'b0);
    send_atom(-24'sd5000, 24'sd7, 24'sd9, 16'd0, 1'b1);
    send_atom(24'sd1000, -24'sd1000, 24'sd0, 16'd64, 1'b0);
    send_atom(24'sh800000, 24'sh7FFFFF, 24'sd0, 16'hFFFF, 1'b1);
    wait_idle();

    // 20 and 10 angstrom boxes and the widest box on z
    set_boxes(23'd5120, 23'd2560, EXT_MAX);
    // exactly half an extent, the mirror case, just below, zero delta
    send_atom(24'sd0, 24'sd0, 24'sd0, 16'd64, 1'b0);
    send_atom(24'sd2560, 24'sd1280, 24'sd100, 16'd128, 1'b0);
    send_atom(-24'sd2560, -24'sd1280, 24'sh800000, 16'd3, 1'b0);
    send_atom(24'sd2559, 24'sd1279, 24'sh7FFFFF, 16'd1000, 1'b0);
    send_atom(24'sd0, 24'sd0, 24'sd0, 16'd77, 1'b1);
    // opposite corners of the coordinate range
    send_atom(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 1'b0);
    send_atom(24'sh800000, 24'sh800000, 24'sh800000, 16'hFFFF, 1'b1);
    // centroid past the box center but below one extent is not folded
    send_atom(24'sd5000, 24'sd2500, 24'sd8388000, 16'd1, 1'b0);
    send_atom(24'sd5100, 24'sd2550, 24'sd8388100, 16'd1, 1'b1);
    // negative centroid moves up by one extent
    send_atom(-24'sd10, -24'sd10, -24'sd10, 16'd1, 1'b0);
    send_atom(-24'sd20, -24'sd20, -24'sd20, 16'd1, 1'b1);
    // quotient truncates toward zero
    send_atom(-24'sd3, 24'sd3, 24'sd0, 16'd1, 1'b0);
    send_atom(-24'sd4, 24'sd4, 24'sd1, 16'd2, 1'b1);
    wait_idle();

    // random groups under several box settings
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        set_boxes(EXT_MAX, EXT_MAX, EXT_MAX);
      else if (ph == 1)
        set_boxes('0, '0, '0);
      else
        set_boxes(pick_extent(), pick_extent(), pick_extent());
      tx_idle = (ph != PRESS_PHASE) && ($urandom_range(0, 3) != 0);
      rx_idle = (ph != PRESS_PHASE) && ($urandom_range(0, 3) != 0);
      // back-to-back short groups against a held-off receiver fill the block
      if (ph == PRESS_PHASE) hold_request = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (ph == PRESS_PHASE)
          len = $urandom_range(1, 2);
        else if ($urandom_range(0, 9) == 0)
          len = $urandom_range(9, 40);
        else
          len = $urandom_range(1, 6);
        send_group(len, $urandom_range(0, 15) == 0);
        sent += len;
      end
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/pcom_pkg.sv
hdl/pcom_ctrl.sv
hdl/pcom_datapath.sv
hdl/periodic_center_of_mass.sv
verif/tb_top.sv
